### hw/rtl/pidip_pkg.sv
`default_nettype none

package pidip_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int GAIN_W         = 16;
    localparam int SUM_W          = 32;
    localparam int OUT_W          = 32;

    // error and its first difference are exact at these widths
    localparam int ERR_W   = SAMPLE_WIDTH + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int ITERM_W = (SUM_W > ERR_W) ? SUM_W : ERR_W;
    localparam int ACC_W   = ITERM_W + 1;

    localparam int P_W   = GAIN_W + ERR_W;
    localparam int I_W   = GAIN_W + ITERM_W;
    localparam int D_W   = GAIN_W + DIFF_W;
    localparam int RAW_W = GAIN_W + ((ITERM_W > DIFF_W) ? ITERM_W : DIFF_W) + 2;

    localparam int CFG_W     = (SAMPLE_WIDTH > GAIN_W) ? SAMPLE_WIDTH : GAIN_W;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT = 3'd0,
        REG_GAIN_P   = 3'd1,
        REG_GAIN_I   = 3'd2,
        REG_GAIN_D   = 3'd3,
        REG_MODE     = 3'd4
    } t_reg_idx;

    typedef enum logic {
        MODE_INC = 1'b0,
        MODE_POS = 1'b1
    } t_mode;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] setpoint;
        logic signed [GAIN_W-1:0]       gain_p;
        logic signed [GAIN_W-1:0]       gain_i;
        logic signed [GAIN_W-1:0]       gain_d;
        t_mode                          mode;
    } t_cfg;

    typedef struct packed {
        logic signed [P_W-1:0] p;
        logic signed [I_W-1:0] i;
        logic signed [D_W-1:0] d;
        logic                  clip;
    } t_prod;

endpackage

`default_nettype wire

### hw/rtl/pidip_cfg_regs.sv
`default_nettype none

module pidip_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [pidip_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [pidip_pkg::CFG_W-1:0]      i_cfg_data,
    output pidip_pkg::t_cfg                       o_cfg
);
    import pidip_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_SETPOINT: n_cfg.setpoint = i_cfg_data[SAMPLE_WIDTH-1:0];
                REG_GAIN_P:   n_cfg.gain_p   = i_cfg_data[GAIN_W-1:0];
                REG_GAIN_I:   n_cfg.gain_i   = i_cfg_data[GAIN_W-1:0];
                REG_GAIN_D:   n_cfg.gain_d   = i_cfg_data[GAIN_W-1:0];
                REG_MODE:     n_cfg.mode     = t_mode'(i_cfg_data[0]);
                default:      n_cfg          = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint <= '0;
            r_cfg.gain_p   <= '0;
            r_cfg.gain_i   <= '0;
            r_cfg.gain_d   <= '0;
            r_cfg.mode     <= MODE_INC;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pidip_err_stage.sv
`default_nettype none

module pidip_err_stage (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire pidip_pkg::t_cfg                       i_cfg,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic signed [pidip_pkg::SAMPLE_WIDTH-1:0] i_feedback,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output pidip_pkg::t_prod                           o_prod
);
    import pidip_pkg::*;

    logic signed [ERR_W-1:0] r_last;
    logic signed [ERR_W-1:0] r_older;
    logic signed [SUM_W-1:0] r_sum;
    logic                    r_valid;
    t_prod                   r_prod;

    logic signed [ERR_W-1:0]   w_err;
    logic signed [DIFF_W-1:0]  w_diff;
    logic signed [ACC_W-1:0]   w_acc;
    logic [ACC_W-SUM_W:0]      w_acc_top;
    logic                      w_sum_clip;
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [ITERM_W-1:0] w_iterm;
    logic signed [DIFF_W-1:0]  w_dterm;
    logic                      w_fire;
    t_prod                     n_prod;

    assign o_ready = !r_valid || i_ready;
    assign w_fire  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_prod  = r_prod;

    always_comb begin
        w_err  = ERR_W'(i_cfg.setpoint) - ERR_W'(i_feedback);
        w_diff = DIFF_W'(w_err) - DIFF_W'(r_last);

        // saturating accumulate: clip when the bits above the sign disagree
        w_acc      = ACC_W'(r_sum) + ACC_W'(w_err);
        w_acc_top  = w_acc[ACC_W-1:SUM_W-1];
        w_sum_clip = !(&w_acc_top) && (|w_acc_top);
        if (w_sum_clip) begin
            w_sum = w_acc[ACC_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            w_sum = w_acc[SUM_W-1:0];
        end

        if (i_cfg.mode == MODE_POS) begin
            w_iterm = ITERM_W'(w_sum);
            w_dterm = w_diff;
        end else begin
            w_iterm = ITERM_W'(r_last);
            w_dterm = DIFF_W'(r_older);
        end

        n_prod.p    = P_W'(i_cfg.gain_p) * P_W'(w_err);
        n_prod.i    = I_W'(i_cfg.gain_i) * I_W'(w_iterm);
        n_prod.d    = D_W'(i_cfg.gain_d) * D_W'(w_dterm);
        n_prod.clip = (i_cfg.mode == MODE_POS) && w_sum_clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_last  <= '0;
            r_older <= '0;
            r_sum   <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (w_fire) begin
                r_last <= w_err;
                if (i_cfg.mode == MODE_POS) begin
                    r_sum <= w_sum;
                end else begin
                    r_older <= r_last;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_prod <= n_prod;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pidip_out_stage.sv
`default_nettype none

module pidip_out_stage (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire pidip_pkg::t_prod                  i_prod,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [pidip_pkg::OUT_W-1:0]     o_drive,
    output logic                                   o_saturated
);
    import pidip_pkg::*;

    localparam logic signed [RAW_W-1:0] FRAC_MASK =
        RAW_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

    logic                    r_valid;
    logic signed [OUT_W-1:0] r_drive;
    logic                    r_sat;

    logic signed [RAW_W-1:0] w_raw;
    logic signed [RAW_W-1:0] w_bias;
    logic signed [RAW_W-1:0] w_q;
    logic [RAW_W-OUT_W:0]    w_q_top;
    logic                    w_clip;
    logic signed [OUT_W-1:0] n_drive;
    logic                    n_sat;

    assign o_ready     = !r_valid || i_ready;
    assign o_valid     = r_valid;
    assign o_drive     = r_drive;
    assign o_saturated = r_sat;

    always_comb begin
        w_raw  = RAW_W'(i_prod.p) - RAW_W'(i_prod.i) + RAW_W'(i_prod.d);
        // bias negatives so the arithmetic shift rounds toward zero
        w_bias = w_raw[RAW_W-1] ? FRAC_MASK : '0;
        w_q    = (w_raw + w_bias) >>> GAIN_FRAC_BITS;

        w_q_top = w_q[RAW_W-1:OUT_W-1];
        w_clip  = !(&w_q_top) && (|w_q_top);
        if (w_clip) begin
            n_drive = w_q[RAW_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end else begin
            n_drive = w_q[OUT_W-1:0];
        end
        n_sat = w_clip || i_prod.clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_drive <= n_drive;
            r_sat   <= n_sat;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pid_inc_pos_controller.sv
// Discrete PID controller, incremental or positional form, signed Q8.8 gains.
//
// Configuration: write setpoint, gain_p, gain_i, gain_d and mode through the
// cfg channel (index 0 to 4, others ignored) while no sample is in flight.
// The cfg channel is always ready; a write takes effect on the next cycle.
//
// Samples: each feedback request on i_valid/o_ready yields exactly one result
// (o_drive, o_saturated) on o_valid/i_ready, in order. A sample passes an input
// register, a product register (error, state update, three gain multiplies)
// and the result register, in that order. One sample is taken every cycle while
// the receiver keeps i_ready high.
//
// When the receiver stalls, the result register holds; ready falls back
// through the stages and the input side stops once all three registers are
// full. Reset clears the valid flags, config, error history and error sum.
`default_nettype none

module pid_inc_pos_controller (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_cfg_valid,
    output logic                                           o_cfg_ready,
    input  wire logic [pidip_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  wire logic [pidip_pkg::CFG_W-1:0]               i_cfg_data,
    input  wire logic                                      i_valid,
    output logic                                           o_ready,
    input  wire logic signed [pidip_pkg::SAMPLE_WIDTH-1:0] i_feedback,
    output logic                                           o_valid,
    input  wire logic                                      i_ready,
    output logic signed [pidip_pkg::OUT_W-1:0]             o_drive,
    output logic                                           o_saturated
);
    import pidip_pkg::*;

    t_cfg  w_cfg;
    t_prod w_prod;
    logic  w_err_ready;
    logic  w_prod_valid;
    logic  w_out_ready;

    logic                           r_in_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_in_fb;

    pidip_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    assign o_ready = !r_in_valid || w_err_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_fb <= i_feedback;
        end
    end

    pidip_err_stage u_err (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_valid    (r_in_valid),
        .o_ready    (w_err_ready),
        .i_feedback (r_in_fb),
        .o_valid    (w_prod_valid),
        .i_ready    (w_out_ready),
        .o_prod     (w_prod)
    );

    pidip_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_prod_valid),
        .o_ready     (w_out_ready),
        .i_prod      (w_prod),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_drive     (o_drive),
        .o_saturated (o_saturated)
    );

`ifndef ASSERT_OFF
    // input back-pressure only when every stage holds a request
    a_full_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_in_valid && w_prod_valid && o_valid))
        else $error("input stalled with an empty stage");

    // nothing appears at the output without a request in the product stage
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !w_prod_valid) |=> !o_valid)
        else $error("result appeared from an empty product stage");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !r_in_valid && !w_prod_valid))
        else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire
